// ----- hw/rtl/rcw_pkg.sv -----
// shared types, codes and helper functions for the reno congestion window block
package rcw_pkg;

	// phase machine, one-hot
	typedef enum logic [2:0] {
		PH_SLOW     = 3'b001,
		PH_RECOVERY = 3'b010,
		PH_AVOID    = 3'b100
	} phase_t;

	// acknowledgement classification as reported on the outcome port
	typedef enum logic [1:0] {
		OUT_NEW  = 2'd0,
		OUT_DUP  = 2'd1,
		OUT_LOSS = 2'd2
	} outcome_t;

	// phase codes as reported on the phase_now port
	localparam logic [1:0] PHASE_CODE_SLOW     = 2'd0;
	localparam logic [1:0] PHASE_CODE_RECOVERY = 2'd1;
	localparam logic [1:0] PHASE_CODE_AVOID    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_INIT_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_SEGMENT_SIZE   = 2'd1;
	localparam logic [1:0] REG_DUP_LIMIT      = 2'd2;

	// reset values
	localparam logic [31:0] INIT_THRESHOLD_RST = 32'd8192;
	localparam logic [15:0] SEGMENT_SIZE_RST   = 16'd1024;
	localparam logic [3:0]  DUP_LIMIT_RST      = 4'd3;
	localparam logic [31:0] WINDOW_RST         = 32'd1;
	localparam logic [31:0] NEXT_SEQ_RST       = 32'd1;

	// window bump on entering fast recovery
	localparam logic [31:0] RECOVERY_INFLATE = 32'd3;
	localparam logic [3:0]  DUP_COUNT_MAX    = 4'd15;
	localparam logic [31:0] WINDOW_MAX       = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] initial_threshold;
		logic [15:0] segment_size;
		logic [3:0]  duplicate_limit;
	} rcw_cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] window;
		logic [31:0] threshold;
		logic [3:0]  dup_count;
		logic [31:0] next_seq;
		logic [31:0] ack_count;
		logic [31:0] last_ack;
		logic        last_ack_valid;
	} rcw_state_t;

	// saturating 32-bit add
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? WINDOW_MAX : s[31:0];
	endfunction

	function automatic logic [1:0] phase_code(input phase_t p);
		logic [1:0] c;
		case (p)
			PH_RECOVERY: c = PHASE_CODE_RECOVERY;
			PH_AVOID:    c = PHASE_CODE_AVOID;
			default:     c = PHASE_CODE_SLOW;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/reno_congestion_window.sv -----
// top level of the reno congestion window block: handshakes, state and result registers
//
// Input channel (in_valid/in_ready) carries one received acknowledgement
// (ack_number) and the length of the segment it answers (segment_length).
// Output channel (out_valid/out_ready) returns one result per transaction:
// the classification, the phase and the window, threshold, next sequence and
// acknowledgement count after the update.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// initial_threshold (0), segment_size (1) and duplicate_limit (2); writing
// initial_threshold also loads the live threshold. cfg_ready is always high;
// writes are meant to happen while no transaction is in flight.
// An accepted item sits in the input register; the state update runs in one
// pass and lands in the result register.
// Throughput is one item per cycle unless the receiver stalls; the state
// registers close the loop, so back-to-back items see each other's updates.
// A stalled receiver holds the result register; the input register still
// takes one more item, after which in_ready drops until out_ready returns.
// Reset clears the handshakes and loads the reset configuration and state
// (slow start, window 1, threshold 8192, next sequence 1).
module reno_congestion_window (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// acknowledgement input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] ack_number,
	input  logic [15:0] segment_length,
	// results
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  outcome,
	output logic [1:0]  phase_now,
	output logic [31:0] window_now,
	output logic [31:0] threshold_now,
	output logic [31:0] sequence_now,
	output logic [31:0] ack_counter_now
);
	import rcw_pkg::*;

	rcw_cfg_t    cfg_q;
	rcw_state_t  state_q;
	rcw_state_t  state_d;
	outcome_t    step_kind;
	logic        valid_s1;
	logic [31:0] ack_s1;
	logic [15:0] len_s1;
	logic        out_valid_q;
	logic        advance;
	logic        cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_threshold <= INIT_THRESHOLD_RST;
			cfg_q.segment_size <= SEGMENT_SIZE_RST;
			cfg_q.duplicate_limit <= DUP_LIMIT_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_INIT_THRESHOLD: cfg_q.initial_threshold <= cfg_data;
				REG_SEGMENT_SIZE:   cfg_q.segment_size <= cfg_data[15:0];
				REG_DUP_LIMIT:      cfg_q.duplicate_limit <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ack_s1 <= ack_number;
			len_s1 <= segment_length;
		end
	end

	// next-state logic
	rcw_step u_step (
		.cur            (state_q),
		.cfg            (cfg_q),
		.ack_number     (ack_s1),
		.segment_length (len_s1),
		.nxt            (state_d),
		.kind           (step_kind)
	);

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_SLOW;
			state_q.window <= WINDOW_RST;
			state_q.threshold <= INIT_THRESHOLD_RST;
			state_q.dup_count <= '0;
			state_q.next_seq <= NEXT_SEQ_RST;
			state_q.ack_count <= '0;
			state_q.last_ack <= '0;
			state_q.last_ack_valid <= 1'b0;
		end else if (cfg_wr && cfg_index == REG_INIT_THRESHOLD) begin
			state_q.threshold <= cfg_data;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outcome <= step_kind;
			phase_now <= phase_code(state_d.phase);
			window_now <= state_d.window;
			threshold_now <= state_d.threshold;
			sequence_now <= state_d.next_seq;
			ack_counter_now <= state_d.ack_count;
		end
	end

	// an item leaving the input register always shows up as a result
	a_advance_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item did not reach the result register");

	// the input side only stalls when both registers are full and the receiver waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a full pipeline");

	// only a new acknowledgement moves the acknowledgement count
	a_count_on_new: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_kind != OUT_NEW) |=> state_q.ack_count == $past(state_q.ack_count))
		else $error("ack count moved without a new acknowledgement");

	// once an item was processed a previous acknowledgement is on record
	a_last_ack_seen: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> state_q.last_ack_valid)
		else $error("last acknowledgement not recorded");

	// the reported window and threshold are the ones just stored in the state
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> window_now == state_q.window && threshold_now == state_q.threshold)
		else $error("result register disagrees with the state registers");

endmodule

// ----- hw/rtl/rcw_step.sv -----
// next-state logic: classifies one acknowledgement and steps the phase machine
module rcw_step (
	input  rcw_pkg::rcw_state_t cur,
	input  rcw_pkg::rcw_cfg_t   cfg,
	input  logic [31:0]         ack_number,
	input  logic [15:0]         segment_length,
	output rcw_pkg::rcw_state_t nxt,
	output rcw_pkg::outcome_t   kind
);
	import rcw_pkg::*;

	logic [31:0] seq_target;
	logic [31:0] half_window;
	logic [31:0] win_plus_seg;
	logic [31:0] win_double;
	logic        dup_hit;
	rcw_state_t  cls;

	assign seq_target   = cur.next_seq + {16'd0, segment_length};
	assign half_window  = cur.window >> 1;
	assign win_plus_seg = sat_add(cur.window, {16'd0, cfg.segment_size});
	assign win_double   = cur.window[31] ? WINDOW_MAX : {cur.window[30:0], 1'b0};

	// classify the acknowledgement and update the bookkeeping fields
	always_comb begin
		cls = cur;
		kind = OUT_LOSS;
		if (ack_number == seq_target) begin
			kind = OUT_NEW;
			cls.next_seq = seq_target;
			cls.ack_count = cur.ack_count + 32'd1;
		end else if (cur.last_ack_valid && ack_number == cur.last_ack) begin
			kind = OUT_DUP;
			if (cur.dup_count != DUP_COUNT_MAX) begin
				cls.dup_count = cur.dup_count + 4'd1;
			end
		end
		cls.last_ack = ack_number;
		cls.last_ack_valid = 1'b1;
	end

	assign dup_hit = (cls.dup_count >= cfg.duplicate_limit);

	// phase machine
	always_comb begin
		nxt = cls;
		case (cur.phase)
			PH_AVOID: begin
				if (dup_hit) begin
					nxt.phase = PH_RECOVERY;
					nxt.threshold = half_window;
					nxt.window = half_window + RECOVERY_INFLATE;
				end else if (kind == OUT_LOSS) begin
					nxt.phase = PH_SLOW;
					nxt.threshold = half_window;
					nxt.window = WINDOW_RST;
					nxt.dup_count = '0;
				end else if (kind == OUT_NEW) begin
					nxt.window = win_plus_seg;
					nxt.dup_count = '0;
				end
			end
			PH_RECOVERY: begin
				if (kind == OUT_LOSS) begin
					nxt.phase = PH_SLOW;
					nxt.threshold = half_window;
					nxt.window = WINDOW_RST;
					nxt.dup_count = '0;
				end else if (kind == OUT_NEW) begin
					nxt.phase = PH_AVOID;
					nxt.window = cur.threshold;
					nxt.dup_count = '0;
					nxt.ack_count = cls.ack_count + 32'd1;
					nxt.next_seq = ack_number;
				end else begin
					nxt.window = win_plus_seg;
				end
			end
			default: begin
				if (cur.window >= cur.threshold) begin
					nxt.phase = PH_AVOID;
					nxt.window = win_plus_seg;
					nxt.dup_count = '0;
				end else if (dup_hit) begin
					nxt.phase = PH_RECOVERY;
					nxt.threshold = half_window;
					nxt.window = half_window + RECOVERY_INFLATE;
				end else if (kind == OUT_NEW) begin
					nxt.window = win_double;
					nxt.dup_count = '0;
				end
			end
		endcase
	end

endmodule
